// ----- rtl/rldpd_pkg.sv -----
package rldpd_pkg;

	localparam int unsigned MAX_STATE_BYTES = 4096;

	localparam int unsigned DLEN_W = 16;
	localparam int unsigned TPOS_W = 13;
	localparam int unsigned WPOS_W = 12;
	localparam int unsigned BYTE_W = 8;

	localparam logic [TPOS_W-1:0] TPOS_MAX  = '1;
	localparam logic [TPOS_W-1:0] SIZE_CAP  = TPOS_W'(MAX_STATE_BYTES);
	localparam logic [BYTE_W-1:0] SKIP_MARK = 8'h00;

	typedef enum logic {
		REG_DIFF_LENGTH = 1'b0,
		REG_IMAGE_SIZE  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_MARKER  = 2'd0,
		PH_SKIP    = 2'd1,
		PH_LITERAL = 2'd2,
		PH_HALTED  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] delta_byte;
		logic              start_req;
	} delta_t;

	typedef struct packed {
		logic              write_enable;
		logic [WPOS_W-1:0] write_position;
		logic [BYTE_W-1:0] write_value;
		logic              halted;
	} result_t;

	typedef struct packed {
		phase_t            phase;
		logic [BYTE_W-1:0] literal_left;
		logic [TPOS_W-1:0] target_position;
		logic [DLEN_W-1:0] delta_position;
	} dec_state_t;

endpackage

// ----- rtl/rldpd_step.sv -----
module rldpd_step (
	input  rldpd_pkg::dec_state_t              cur,
	input  rldpd_pkg::delta_t                  item,
	input  logic [rldpd_pkg::DLEN_W-1:0]       diff_length,
	input  logic [rldpd_pkg::TPOS_W-1:0]       size_in_use,
	output rldpd_pkg::dec_state_t              nxt,
	output rldpd_pkg::result_t                 res
);

	rldpd_pkg::dec_state_t          st;
	logic [rldpd_pkg::DLEN_W-1:0]   dp_inc;
	logic [rldpd_pkg::DLEN_W:0]     dp_run;
	logic [rldpd_pkg::TPOS_W:0]     tp_run;
	logic [rldpd_pkg::BYTE_W-1:0]   lit_dec;
	logic                           recheck;

	always_comb begin
		st = cur;
		if (item.start_req) begin
			st.phase           = rldpd_pkg::PH_MARKER;
			st.literal_left    = '0;
			st.target_position = '0;
			st.delta_position  = '0;
		end
		if (st.phase == rldpd_pkg::PH_MARKER &&
		    (st.delta_position >= diff_length || st.target_position >= size_in_use))
			st.phase = rldpd_pkg::PH_HALTED;

		dp_inc  = st.delta_position + rldpd_pkg::DLEN_W'(1);
		dp_run  = {1'b0, dp_inc} + (rldpd_pkg::DLEN_W+1)'(item.delta_byte);
		tp_run  = {1'b0, st.target_position} + (rldpd_pkg::TPOS_W+1)'(item.delta_byte);
		lit_dec = st.literal_left - rldpd_pkg::BYTE_W'(1);

		nxt     = st;
		res     = '0;
		recheck = 1'b0;

		unique case (st.phase)
			rldpd_pkg::PH_MARKER: begin
				nxt.delta_position = dp_inc;
				if (item.delta_byte == rldpd_pkg::SKIP_MARK) begin
					nxt.phase = (dp_inc >= diff_length) ? rldpd_pkg::PH_HALTED
					                                    : rldpd_pkg::PH_SKIP;
				end else if (dp_run > {1'b0, diff_length} || tp_run > {1'b0, size_in_use}) begin
					nxt.phase = rldpd_pkg::PH_HALTED;
				end else begin
					nxt.literal_left = item.delta_byte;
					nxt.phase        = rldpd_pkg::PH_LITERAL;
				end
			end
			rldpd_pkg::PH_SKIP: begin
				nxt.delta_position  = dp_inc;
				nxt.target_position = tp_run[rldpd_pkg::TPOS_W] ? rldpd_pkg::TPOS_MAX
				                                                : tp_run[rldpd_pkg::TPOS_W-1:0];
				nxt.phase = rldpd_pkg::PH_MARKER;
				recheck   = 1'b1;
			end
			rldpd_pkg::PH_LITERAL: begin
				res.write_enable   = 1'b1;
				res.write_position = st.target_position[rldpd_pkg::WPOS_W-1:0];
				res.write_value    = item.delta_byte;
				nxt.delta_position = dp_inc;
				if (st.target_position != rldpd_pkg::TPOS_MAX)
					nxt.target_position = st.target_position + rldpd_pkg::TPOS_W'(1);
				nxt.literal_left = lit_dec;
				if (lit_dec == '0) begin
					nxt.phase = rldpd_pkg::PH_MARKER;
					recheck   = 1'b1;
				end
			end
			rldpd_pkg::PH_HALTED: begin
			end
			default: begin
			end
		endcase

		if (recheck &&
		    (nxt.delta_position >= diff_length || nxt.target_position >= size_in_use))
			nxt.phase = rldpd_pkg::PH_HALTED;

		res.halted = (nxt.phase == rldpd_pkg::PH_HALTED);
	end

endmodule

// ----- rtl/run_length_delta_patch_decoder.sv -----
// Run-length delta patch decoder.
// delta channel (delta_valid/delta_ready/delta): one delta byte per
// transaction, with start_req set on the first byte of a delta.
// result channel (result_valid/result_ready/result): exactly one result per
// delta transaction, in order: a target write (enable, position, value) and
// the halted flag after that byte.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register 0 is
// diff_length, register 1 is the target image size. Always ready; write only while idle.
// The result is registered and appears in the cycle after the delta transaction.
// Throughput: one byte per cycle while the result register keeps draining; the decode and counter update for a byte
// is a single pass from the decoder state into the result register.
// delta_ready is high while the result register is empty or being emptied,
// so a stalled receiver holds one result and stops input after that.
// Reset clears the decoder state to expect-marker with zero positions,
// diff_length to 0, the image size to 1, and empties the result register.
module run_length_delta_patch_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             delta_valid,
	output logic                             delta_ready,
	input  rldpd_pkg::delta_t                delta,
	output logic                             result_valid,
	input  logic                             result_ready,
	output rldpd_pkg::result_t               result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  rldpd_pkg::reg_idx_t              cfg_index,
	input  logic [rldpd_pkg::DLEN_W-1:0]     cfg_data
);

	rldpd_pkg::dec_state_t          state_q;
	rldpd_pkg::dec_state_t          state_nxt;
	rldpd_pkg::result_t             res_nxt;
	rldpd_pkg::result_t             result_q;
	logic                           result_valid_q;
	logic [rldpd_pkg::DLEN_W-1:0]   diff_length_q;
	logic [rldpd_pkg::TPOS_W-1:0]   image_size_q;
	logic [rldpd_pkg::TPOS_W-1:0]   size_in_use;
	logic                           take;

	assign size_in_use  = (image_size_q > rldpd_pkg::SIZE_CAP) ? rldpd_pkg::SIZE_CAP
	                                                          : image_size_q;
	assign delta_ready  = !result_valid_q || result_ready;
	assign take         = delta_valid && delta_ready;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	rldpd_step u_step (
		.cur         (state_q),
		.item        (delta),
		.diff_length (diff_length_q),
		.size_in_use (size_in_use),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase           <= rldpd_pkg::PH_MARKER;
			state_q.literal_left    <= '0;
			state_q.target_position <= '0;
			state_q.delta_position  <= '0;
			result_valid_q          <= 1'b0;
			diff_length_q           <= '0;
			image_size_q            <= rldpd_pkg::TPOS_W'(1);
		end else begin
			if (take) begin
				state_q        <= state_nxt;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					rldpd_pkg::REG_DIFF_LENGTH: diff_length_q <= cfg_data;
					rldpd_pkg::REG_IMAGE_SIZE:
						image_size_q <= cfg_data[rldpd_pkg::TPOS_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			result_q <= res_nxt;
	end

endmodule
